### rtl/wsu_pkg.sv
// Shared types and header layout constants for the frame unmasker.
package wsu_pkg;

  // Low seven bits of byte 1 that select an extended header
  localparam logic [6:0] CodeMedium = 7'd126;
  localparam logic [6:0] CodeLong   = 7'd127;

  // Header sizes (payload offsets) for each layout
  localparam logic [3:0] SizeShort  = 4'd6;
  localparam logic [3:0] SizeMedium = 4'd8;
  localparam logic [3:0] SizeLong   = 4'd14;
  localparam logic [3:0] MaskBytes  = 4'd4;

  // Header byte that carries the length code
  localparam logic [3:0] PosLenCode = 4'd1;

  // One result item as it leaves the unmasking core
  typedef struct packed {
    logic       short_frame;
    logic       end_of_frame;
    logic       has_data;
    logic [7:0] payload_byte;
  } wsu_res_t;

endpackage

### rtl/wsu_core.sv
// Header tracking, mask capture and payload unmasking for one byte per step.
module wsu_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      byte_i,
  input  logic            last_i,
  output logic            res_valid_o,
  output wsu_pkg::wsu_res_t res_o
);
  import wsu_pkg::*;

  logic [3:0]  hdr_pos_q, hdr_pos_d;
  logic [3:0]  hdr_size_q, hdr_size_d;
  logic [31:0] mask_q, mask_d;
  logic [1:0]  phase_q, phase_d;

  logic [3:0]  size_eff;
  logic [3:0]  mask_start;
  logic [3:0]  pos_inc;
  logic [1:0]  mask_idx;
  logic        in_hdr;
  logic [7:0]  key_byte;

  // Header size as it stands after this byte
  always_comb begin
    size_eff = hdr_size_q;
    if (hdr_pos_q == PosLenCode) begin
      case (byte_i[6:0])
        CodeMedium: size_eff = SizeMedium;
        CodeLong:   size_eff = SizeLong;
        default:    size_eff = SizeShort;
      endcase
    end
  end

  assign in_hdr     = (hdr_pos_q < hdr_size_q);
  assign mask_start = size_eff - MaskBytes;
  assign mask_idx   = 2'(hdr_pos_q - mask_start);
  assign pos_inc    = hdr_pos_q + 4'd1;
  assign key_byte   = mask_q[8*phase_q +: 8];

  // Result and next state
  always_comb begin
    hdr_pos_d  = hdr_pos_q;
    hdr_size_d = hdr_size_q;
    mask_d     = mask_q;
    phase_d    = phase_q;
    res_o      = '0;
    if (in_hdr) begin
      res_valid_o        = last_i;
      res_o.end_of_frame = 1'b1;
      res_o.short_frame  = (pos_inc < size_eff);
      hdr_pos_d          = pos_inc;
      hdr_size_d         = size_eff;
      if (hdr_pos_q >= mask_start) begin
        mask_d[8*mask_idx +: 8] = byte_i;
      end
    end else begin
      res_valid_o        = 1'b1;
      res_o.payload_byte = byte_i ^ key_byte;
      res_o.has_data     = 1'b1;
      res_o.end_of_frame = last_i;
      phase_d            = phase_q + 2'd1;
    end
    // Frame ends: back to the start-of-frame state
    if (last_i) begin
      hdr_pos_d  = '0;
      hdr_size_d = SizeShort;
      mask_d     = '0;
      phase_d    = '0;
    end
  end

  // Frame state registers, updated once per processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos_q  <= '0;
      hdr_size_q <= SizeShort;
      mask_q     <= '0;
      phase_q    <= '0;
    end else if (step_i) begin
      hdr_pos_q  <= hdr_pos_d;
      hdr_size_q <= hdr_size_d;
      mask_q     <= mask_d;
      phase_q    <= phase_d;
    end
  end

endmodule

### rtl/websocket_frame_unmasker_top.sv
// Top level of the client frame unmasker: input register, core and result register.
// Accepts one frame byte per cycle while no waiting result blocks it, and gives
// one result per payload byte, each XORed with the rotating four-byte mask, plus
// a single status result when a buffer ends inside the header (short frame, or
// complete header with no payload). Header bytes that do not end the buffer give
// no result. A byte moves from the input register through the core into the
// result register; throughput, one byte per cycle when nothing blocks, is set by
// that single pass through the core. The input side keeps taking bytes while a
// finished result waits, as long as the byte in the input register can move on.
module websocket_frame_unmasker_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] frame_byte
  input  logic       s_axis_tlast,   // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
  output logic [1:0] m_axis_tuser,   // [0] has_data, [1] short_frame
  output logic       m_axis_tlast    // end_of_frame
);
  import wsu_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q;
  wsu_res_t   out_res_q;

  logic       res_valid;
  wsu_res_t   res;
  logic       out_free;
  logic       in_adv;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign in_adv        = in_valid_q && (!res_valid || out_free);
  assign s_axis_tready = !in_valid_q || in_adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  wsu_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_adv),
    .byte_i      (in_byte_q),
    .last_i      (in_last_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_adv && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && in_adv && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q.payload_byte;
  assign m_axis_tuser  = {out_res_q.short_frame, out_res_q.has_data};
  assign m_axis_tlast  = out_res_q.end_of_frame;

endmodule

### rtl/wsu_checker.sv
// Port-level checks on the frame unmasker, bound to its top level.
module wsu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // A status result carries no byte
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'd0)
    else $error("status result with non-zero data");

  // Status results only ever close a frame
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
    else $error("status result without end of frame");

  // Short frame flag never rides on a payload byte
  a_short_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
    else $error("short frame flagged on a data result");

  // A stalled result holds its content
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind websocket_frame_unmasker_top wsu_checker u_wsu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

### tb/sv/websocket_frame_unmasker_checker.sv
// Checker for the frame unmasker: predicts every result and compares the output stream.
module websocket_frame_unmasker_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] frame_byte
  input  logic       s_axis_tlast,   // last_byte
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,   // [7:0] payload_byte
  input  logic [1:0] m_axis_tuser,   // [0] has_data, [1] short_frame
  input  logic       m_axis_tlast,   // end_of_frame
  output int         fail_cnt_o,
  output int         pending_o
);
  import wsu_pkg::*;

  // Predictor state for the frame in progress
  logic [3:0]  hdr_pos;
  logic [3:0]  hdr_size;
  logic [31:0] mask_key;
  logic [1:0]  mask_phase;

  wsu_res_t unmasked_q[$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%m: %s: got 'h%0h, want 'h%0h", what, got, want);
    fail_cnt_o++;
  endtask

  // Back to the start of a frame
  function automatic void frame_restart();
    hdr_pos    = '0;
    hdr_size   = SizeShort;
    mask_key   = '0;
    mask_phase = '0;
  endfunction

  // Absorb one frame byte; returns 1 when the byte gives a result
  function automatic bit unmask_byte(input logic [7:0] b, input logic last,
                                     output wsu_res_t res);
    logic [3:0] key_base;
    logic [1:0] k;
    res = '0;
    if (hdr_pos < hdr_size) begin
      // byte 1 picks the layout before the mask position is judged
      if (hdr_pos == PosLenCode) begin
        if (b[6:0] == CodeMedium) hdr_size = SizeMedium;
        else if (b[6:0] == CodeLong) hdr_size = SizeLong;
        else hdr_size = SizeShort;
      end
      key_base = hdr_size - MaskBytes;
      if (hdr_pos >= key_base) begin
        k = 2'(hdr_pos - key_base);
        mask_key[8*k +: 8] = b;
      end
      hdr_pos = hdr_pos + 4'd1;
      if (!last) return 1'b0;
      // buffer ended in the header: status only
      res.end_of_frame = 1'b1;
      res.short_frame  = (hdr_pos < hdr_size);
      frame_restart();
      return 1'b1;
    end
    res.payload_byte = b ^ mask_key[8*mask_phase +: 8];
    res.has_data     = 1'b1;
    res.end_of_frame = last;
    mask_phase       = mask_phase + 2'd1;
    if (last) frame_restart();
    return 1'b1;
  endfunction

  // Compare the output transaction first, then predict from the input one
  always @(posedge clk_i or negedge rst_ni) begin
    wsu_res_t want;
    wsu_res_t res;
    if (!rst_ni) begin
      frame_restart();
      unmasked_q.delete();
      pending_o  = 0;
      fail_cnt_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (unmasked_q.size() == 0) begin
          report_mismatch("result with nothing pending", m_axis_tdata, 0);
        end else begin
          want = unmasked_q.pop_front();
          if (m_axis_tdata !== want.payload_byte)
            report_mismatch("payload_byte", m_axis_tdata, want.payload_byte);
          if (m_axis_tuser[0] !== want.has_data)
            report_mismatch("has_data", m_axis_tuser[0], want.has_data);
          if (m_axis_tlast !== want.end_of_frame)
            report_mismatch("end_of_frame", m_axis_tlast, want.end_of_frame);
          if (m_axis_tuser[1] !== want.short_frame)
            report_mismatch("short_frame", m_axis_tuser[1], want.short_frame);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (unmask_byte(s_axis_tdata, s_axis_tlast, res)) unmasked_q.push_back(res);
      end
      pending_o = unmasked_q.size();
    end
  end

endmodule

### tb/sv/websocket_frame_unmasker_top_tb.sv
// Stimulus and verdict for the frame unmasker, with the checker beside the block.
module websocket_frame_unmasker_top_tb;
  import wsu_pkg::*;

  localparam int NumItems   = 1900;
  localparam int CycleLimit = 500000;
  localparam int DrainWait  = 20;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] frame_byte
  logic       s_axis_tlast;   // last_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] payload_byte
  logic [1:0] m_axis_tuser;   // [0] has_data, [1] short_frame
  logic       m_axis_tlast;   // end_of_frame

  int fail_cnt;
  int pending_cnt;
  int cycle_cnt;
  int sent_items;
  int burst_left;
  bit steady;
  int hold_cycles;

  logic [7:0] frame_buf[$];

  websocket_frame_unmasker_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  websocket_frame_unmasker_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending_cnt)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("websocket_frame_unmasker_top: mismatch");
    $finish;
  end

  // Receiver: a random stall mode holds for a random stretch; a hold-off overrides it
  initial begin
    int mode;
    int phase_left;
    logic [7:0] pattern;
    int step;
    m_axis_tready = 1'b0;
    mode       = 0;
    phase_left = 0;
    pattern    = 8'hff;
    step       = 0;
    forever begin
      @(negedge clk_i);
      if (phase_left == 0) begin
        mode       = $urandom_range(0, 3);
        phase_left = $urandom_range(64, 256);
        pattern    = 8'($urandom());
      end
      phase_left--;
      step++;
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 9) < 7);
          2: m_axis_tready <= pattern[step % 8];
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // One input transaction; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = steady ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_items++;
    @(negedge clk_i);
  endtask

  // Whole buffer, flagged last on its final byte
  task automatic send_frame_buf();
    for (int i = 0; i < frame_buf.size(); i++)
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    frame_buf.delete();
  endtask

  // Sender goes quiet until every result is out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (pending_cnt != 0);
  endtask

  // Stimulus and verdict
  initial begin
    int kind;
    int hsize;
    int flen;
    logic [6:0] code;
    bit held;
    bit paused;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    sent_items    = 0;
    burst_left    = 0;
    steady        = 1'b0;
    hold_cycles   = 0;
    held          = 1'b0;
    paused        = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // one-byte buffer: byte 1 never comes
    frame_buf = '{8'h81};
    send_frame_buf();
    // short layout, code 0, two payload bytes at the extremes
    frame_buf = '{8'h81, 8'h80, 8'hff, 8'h00, 8'ha5, 8'h5a, 8'hff, 8'h00};
    send_frame_buf();
    // medium layout cut short inside the extended length
    frame_buf = '{8'h82, 8'hfe, 8'h00};
    send_frame_buf();
    // long layout with a complete header and no payload
    frame_buf = '{8'h00, 8'h7f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hff, 8'hff,
                  8'h12, 8'h34, 8'h56, 8'h78};
    send_frame_buf();

    // Random frames: mostly well formed, some cut short, a few one-byte buffers
    while (sent_items < NumItems) begin
      if ($urandom_range(0, 9) == 0) steady = ~steady;
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 2))
        0: begin code = CodeMedium; hsize = int'(SizeMedium); end
        1: begin code = CodeLong;   hsize = int'(SizeLong);   end
        default: begin code = 7'($urandom_range(0, 125)); hsize = int'(SizeShort); end
      endcase
      if (kind < 80) begin
        flen = hsize + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 64)
                                                    : $urandom_range(0, 24));
      end else if (kind < 95) begin
        flen = $urandom_range(2, hsize);
      end else begin
        flen = 1;
      end
      for (int i = 0; i < flen; i++) begin
        if (i == 1) frame_buf.push_back({1'($urandom()), code});
        else frame_buf.push_back(8'($urandom()));
      end
      send_frame_buf();

      // long receiver hold-off while bytes keep coming
      if (!held && sent_items >= 600) begin
        held = 1'b1;
        hold_cycles = 400;
      end
      // sender pause until the output side has caught up
      if (!paused && sent_items >= 1200) begin
        paused = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (DrainWait) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("websocket_frame_unmasker_top: match");
    end else begin
      $display("websocket_frame_unmasker_top: mismatch");
    end
    $finish;
  end

endmodule

### websocket_frame_unmasker_top.f
rtl/wsu_pkg.sv
rtl/wsu_core.sv
rtl/websocket_frame_unmasker_top.sv
rtl/wsu_checker.sv
tb/sv/websocket_frame_unmasker_checker.sv
tb/sv/websocket_frame_unmasker_top_tb.sv
